FILE: hw/rtl/pls_pkg.sv
// Shared widths, operation codes and status codes of the positional list store.
package pls_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned CNT_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ALL = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

endpackage

FILE: hw/rtl/pls_req_if.sv
// Request channel of the positional list store: valid/ready plus request fields.
interface pls_req_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [OP_W-1:0]    operation;
  logic signed [VALUE_W-1:0] value;
  logic        [POS_W-1:0]   position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

FILE: hw/rtl/pls_rsp_if.sv
// Result channel of the positional list store: valid/ready plus result fields.
interface pls_rsp_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] entry_value;
  logic        [IDX_W-1:0]   entry_index;
  logic                      last;
  logic        [ST_W-1:0]    status;
  logic        [CNT_W-1:0]   entry_count;

  modport source (output valid, output entry_value, output entry_index, output last,
                  output status, output entry_count, input ready);
  modport sink   (input valid, input entry_value, input entry_index, input last,
                  input status, input entry_count, output ready);
endinterface

FILE: hw/rtl/positional_list_store_top.sv
// Positional list store: ordered word list in a single-port-style RAM, edited by a sequencer.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------------
//  req_i   | in  | valid / ready | operation, value, position
//  rsp_o   | out | valid / ready | entry_value, entry_index, last, status, entry_count
//
// One request at a time; ready is high only while the sequencer is idle.
// Steps from request transfer to result load (read all: read, then load, for each entry):
//   positional insert/delete: read and rewrite each shifted entry, write or shrink, load;
//   append: write, load; delete last, rejected requests and unused codes: load only.
// The next request is taken the cycle after the last result load. A stalled result
// register holds the sequencer; reset empties the list, RAM is not cleared.
module positional_list_store_top import pls_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pls_req_if.sink      req_i,
  pls_rsp_if.source    rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SH_RD  = 3'd1;
  localparam logic [2:0] S_SH_WR  = 3'd2;
  localparam logic [2:0] S_RA_RD  = 3'd3;
  localparam logic [2:0] S_RA_OUT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [AW-1:0]             ptr_q, ptr_d;
  logic [AW-1:0]             tgt_q, tgt_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      del_q, del_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [ST_W-1:0]           st_q, st_d;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_q;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [IDX_W-1:0]          out_index_q;
  logic                      out_last_q;
  logic [ST_W-1:0]           out_status_q;
  logic [CNT_W-1:0]          out_count_q;

  logic                      out_free, load;
  logic signed [VALUE_W-1:0] ld_value;
  logic [IDX_W-1:0]          ld_index;
  logic                      ld_last;
  logic [ST_W-1:0]           ld_status;

  logic [PW-1:0]             pos_ext, cnt_ext;
  logic [AW-1:0]             slot;
  logic                      full, empty, pos_zero;

  assign pos_ext  = PW'(req_i.position);
  assign cnt_ext  = PW'(count_q);
  assign slot     = AW'(pos_ext - 1'b1);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_zero = (req_i.position == '0);

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    tgt_d     = tgt_q;
    count_d   = count_q;
    del_d     = del_q;
    val_d     = val_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = val_q;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    load      = 1'b0;
    ld_value  = '0;
    ld_index  = '0;
    ld_last   = 1'b1;
    ld_status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          val_d   = req_i.value;
          st_d    = ST_OK;
          state_d = S_DONE;
          unique case (req_i.operation)
            OP_INSERT: begin
              if (pos_zero || (pos_ext > cnt_ext + 1'b1)) begin
                st_d = ST_BADPOS;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                ptr_d   = AW'(count_q);
                tgt_d   = slot;
                del_d   = 1'b0;
                state_d = S_SH_RD;
              end
            end
            OP_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ptr_d   = AW'(count_q);
                tgt_d   = AW'(count_q);
                del_d   = 1'b0;
                state_d = S_SH_RD;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else if (pos_zero || (pos_ext > cnt_ext)) begin
                st_d = ST_BADPOS;
              end else begin
                ptr_d   = slot;
                tgt_d   = AW'(cnt_ext - 1'b1);
                del_d   = 1'b1;
                state_d = S_SH_RD;
              end
            end
            OP_DEL_LAST: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                tgt_d   = AW'(cnt_ext - 1'b1);
                state_d = S_RA_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SH_RD: begin
        if (ptr_q == tgt_q) begin
          // shifting done: drop the new word into the gap, or just shrink
          if (!del_q) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q;
            mem_wdata = val_q;
            count_d   = count_q + 1'b1;
          end else begin
            count_d   = count_q - 1'b1;
          end
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = del_q ? (ptr_q + 1'b1) : (ptr_q - 1'b1);
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rdata_q;
        ptr_d     = del_q ? (ptr_q + 1'b1) : (ptr_q - 1'b1);
        state_d   = S_SH_RD;
      end
      S_RA_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q;
        state_d   = S_RA_OUT;
      end
      S_RA_OUT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_value  = rdata_q;
          ld_index  = IDX_W'(ptr_q);
          ld_last   = (ptr_q == tgt_q);
          ld_status = ST_OK;
          if (ptr_q == tgt_q) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = S_RA_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tgt_q <= tgt_d;
    del_q <= del_d;
    val_q <= val_d;
    st_q  <= st_d;
    if (load) begin
      out_value_q  <= ld_value;
      out_index_q  <= ld_index;
      out_last_q   <= ld_last;
      out_status_q <= ld_status;
      out_count_q  <= CNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_value = out_value_q;
  assign rsp_o.entry_index = out_index_q;
  assign rsp_o.last        = out_last_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above depth");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
    else $error("sequencer idle right after a request transfer");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_EMPTY)) |-> (rsp_o.last && (rsp_o.entry_count == '0)))
    else $error("empty status on a nonempty list or a non-final result");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SH_RD) || (state_q == S_SH_WR)) |-> (cnt_ext <= PW'(DEPTH)))
    else $error("shift running past the list end");
`endif

endmodule
